[hw/rtl/lik_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lik_pkg
// shared types, constants and helper functions of the leg ik datapath
// ----------------------------------------------------------------------------
package lik_pkg;

    localparam int JOINTS_PER_LEG = 3;

    // isqrt chain: 64-bit radicand, one result bit per cell
    localparam int SQ_W     = 64;
    localparam int SQ_STEPS = 32;

    // cordic chain
    localparam int CD_STEPS = 31;
    localparam int ARG_W    = 48;   // atan2 argument width
    localparam int XY_W     = 45;   // rotated vector width
    localparam int Z_W      = 34;   // angle accumulator, 2^-30 rad
    localparam int NORM_MSB = 40;   // vector magnitude lands in [2^40, 2^41)

    localparam logic signed [Z_W-1:0] ANG_PI = 34'sd3373259426;

    // configuration register indexes
    localparam logic [2:0] REG_HIP_LENGTH   = 3'd0;
    localparam logic [2:0] REG_UPPER_LENGTH = 3'd1;
    localparam logic [2:0] REG_LOWER_LENGTH = 3'd2;
    localparam logic [2:0] REG_HIP_OFFSET0  = 3'd3;
    localparam logic [2:0] REG_HIP_OFFSET1  = 3'd4;
    localparam logic [2:0] REG_HIP_OFFSET2  = 3'd5;
    localparam logic [2:0] REG_HIP_OFFSET3  = 3'd6;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } sq_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } cd_t;

    // arctan(2^-i) in 2^-30 rad
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [Z_W-1:0] t;
        case (i)
            5'd0:    t = 34'sd843314857;
            5'd1:    t = 34'sd497837829;
            5'd2:    t = 34'sd263043837;
            5'd3:    t = 34'sd133525159;
            5'd4:    t = 34'sd67021687;
            5'd5:    t = 34'sd33543516;
            5'd6:    t = 34'sd16775851;
            5'd7:    t = 34'sd8388437;
            5'd8:    t = 34'sd4194283;
            5'd9:    t = 34'sd2097149;
            5'd31:   t = 34'sd0;
            default: t = $signed(34'd1 << (5'd30 - i));
        endcase
        return t;
    endfunction

    // index of the highest set bit, zero for a zero word
    function automatic logic [5:0] msb_pos(input logic [ARG_W-1:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < ARG_W; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

[hw/rtl/lik_sqrt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lik_sqrt_cell
// one digit of a restoring integer square root, registered
// ----------------------------------------------------------------------------
module lik_sqrt_cell (
    input  logic          aclk,
    input  logic          en,
    input  logic [4:0]    step,
    input  lik_pkg::sq_t  d_in,
    output lik_pkg::sq_t  d_out
);
    import lik_pkg::*;

    logic [SQ_W-1:0] bit_w;
    logic [SQ_W-1:0] trial;
    sq_t             d_next;
    sq_t             d_reg;

    always_comb begin
        bit_w  = SQ_W'(1) << {(5'd31 - step), 1'b0};
        trial  = d_in.r + bit_w;
        d_next = d_in;
        if (d_in.v >= trial) begin
            d_next.v = d_in.v - trial;
            d_next.r = (d_in.r >> 1) + bit_w;
        end else begin
            d_next.r = d_in.r >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

[hw/rtl/lik_cordic_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lik_cordic_prep
// two-stage atan2 front end: half-plane fold, then magnitude normalization
// ----------------------------------------------------------------------------
module lik_cordic_prep (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [lik_pkg::ARG_W-1:0]  y_in,
    input  logic signed [lik_pkg::ARG_W-1:0]  x_in,
    output lik_pkg::cd_t                      d_out
);
    import lik_pkg::*;

    logic signed [ARG_W:0]  xe, ye, xn, yn, xs, ys;
    logic [ARG_W-1:0]       ax, ay, mx;
    logic signed [Z_W-1:0]  z0;

    logic signed [ARG_W:0]  xa_reg, ya_reg;
    logic signed [Z_W-1:0]  za_reg;
    logic                   zero_reg;
    logic [5:0]             pos_reg;
    cd_t                    d_next, d_reg;

    // fold the left half-plane onto the right one
    always_comb begin
        xe = (ARG_W+1)'(x_in);
        ye = (ARG_W+1)'(y_in);
        xn = xe;
        yn = ye;
        z0 = '0;
        if (x_in < 0) begin
            xn = -xe;
            yn = -ye;
            z0 = (y_in >= 0) ? ANG_PI : -ANG_PI;
        end
        ax = xn[ARG_W-1:0];
        ay = (yn < 0) ? ARG_W'(-yn) : yn[ARG_W-1:0];
        mx = (ay > ax) ? ay : ax;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xa_reg   <= xn;
            ya_reg   <= yn;
            za_reg   <= z0;
            zero_reg <= (x_in == 0) && (y_in == 0);
            pos_reg  <= msb_pos(mx);
        end
    end

    // floor shifts right or plain shifts left
    always_comb begin
        if (pos_reg > 6'(NORM_MSB)) begin
            xs = xa_reg >>> (pos_reg - 6'(NORM_MSB));
            ys = ya_reg >>> (pos_reg - 6'(NORM_MSB));
        end else begin
            xs = xa_reg <<< (6'(NORM_MSB) - pos_reg);
            ys = ya_reg <<< (6'(NORM_MSB) - pos_reg);
        end
        d_next.x    = XY_W'(xs);
        d_next.y    = XY_W'(ys);
        d_next.z    = za_reg;
        d_next.zero = zero_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

[hw/rtl/lik_cordic_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lik_cordic_cell
// one vectoring-mode cordic micro-rotation, registered
// ----------------------------------------------------------------------------
module lik_cordic_cell (
    input  logic          aclk,
    input  logic          en,
    input  logic [4:0]    step,
    input  lik_pkg::cd_t  d_in,
    output lik_pkg::cd_t  d_out
);
    import lik_pkg::*;

    logic signed [XY_W-1:0] dx, dy;
    cd_t                    d_next, d_reg;

    always_comb begin
        dx     = d_in.y >>> step;
        dy     = d_in.x >>> step;
        d_next = d_in;
        if (d_in.y > 0) begin
            d_next.x = d_in.x + dx;
            d_next.y = d_in.y - dy;
            d_next.z = d_in.z + atan_entry(step);
        end else begin
            d_next.x = d_in.x - dx;
            d_next.y = d_in.y + dy;
            d_next.z = d_in.z - atan_entry(step);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

[hw/rtl/leg_inverse_kinematics.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leg_inverse_kinematics
// three-joint leg inverse kinematics solver, fully pipelined
// ----------------------------------------------------------------------------
// One input beat (leg number and foot position) gives one output beat with the
// abduction, hip and knee angles, the leg's first joint index and two flags.
// The block takes a new beat every clock cycle; the only thing that holds it is
// a result beat waiting on m_tready, which freezes the whole pipe. On its way from
// input beat to output beat it passes seven setup stages (hip offset, squares,
// law-of-cosines terms, clamping, normalization, products, radicands), a row of
// 32 square-root digit cells, two product stages, the two-stage atan2 front end
// and a row of 31 cordic cells, plus the output register. Link lengths and hip
// offsets come from the configuration port and must be written while idle.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_wdata,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // leg_id[1:0], foot_x[17:2], foot_y[33:18], foot_z[49:34]
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // abduction_angle[15:0], hip_angle[31:16], knee_angle[47:32],
                                   // first_joint_index[51:48], reach_clamped[52], zero_length[53]
);
    import lik_pkg::*;

    typedef struct packed {
        logic [1:0] leg;
        logic       clamped;
        logic       zero_len;
    } tag_t;

    typedef struct packed {
        logic signed [16:0] px;
        logic signed [16:0] py;
        logic signed [16:0] pz;
        logic signed [16:0] h;
        logic               n_neg;
        logic [30:0]        mag;
        logic               den_zero;
        tag_t               tag;
    } ctx_t;

    // pipe advances whenever the output register is free or being drained
    logic adv;

    // ---------------- configuration registers ----------------
    logic [15:0] hip_len_reg, upper_len_reg, lower_len_reg;
    logic [47:0] offset_reg [0:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hip_len_reg   <= 16'd340;
            upper_len_reg <= 16'd819;
            lower_len_reg <= 16'd819;
            offset_reg[0] <= '0;
            offset_reg[1] <= '0;
            offset_reg[2] <= '0;
            offset_reg[3] <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_HIP_LENGTH:   hip_len_reg   <= cfg_wdata[15:0];
                REG_UPPER_LENGTH: upper_len_reg <= cfg_wdata[15:0];
                REG_LOWER_LENGTH: lower_len_reg <= cfg_wdata[15:0];
                REG_HIP_OFFSET0:  offset_reg[0] <= cfg_wdata;
                REG_HIP_OFFSET1:  offset_reg[1] <= cfg_wdata;
                REG_HIP_OFFSET2:  offset_reg[2] <= cfg_wdata;
                REG_HIP_OFFSET3:  offset_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: foot relative to hip ----------------
    logic [1:0]         in_leg;
    logic [15:0]        in_x, in_y, in_z;
    logic [47:0]        in_off;
    logic signed [16:0] hl17;

    assign in_leg = s_tdata[1:0];
    assign in_x   = s_tdata[17:2];
    assign in_y   = s_tdata[33:18];
    assign in_z   = s_tdata[49:34];
    assign in_off = offset_reg[in_leg];
    assign hl17   = $signed({1'b0, hip_len_reg});

    logic               s1_vld_reg;
    logic [1:0]         s1_leg_reg;
    logic signed [16:0] s1_px_reg, s1_py_reg, s1_pz_reg, s1_h_reg;
    logic [15:0]        s1_u_reg, s1_w_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_leg_reg <= in_leg;
            s1_px_reg  <= $signed({in_x[15], in_x}) - $signed({in_off[15], in_off[15:0]});
            s1_py_reg  <= $signed({in_y[15], in_y}) - $signed({in_off[31], in_off[31:16]});
            s1_pz_reg  <= $signed({in_z[15], in_z}) - $signed({in_off[47], in_off[47:32]});
            // legs 0 and 2 sit on the negative side
            s1_h_reg   <= in_leg[0] ? hl17 : -hl17;
            s1_u_reg   <= upper_len_reg;
            s1_w_reg   <= lower_len_reg;
        end
    end

    // ---------------- stage 2: squares ----------------
    logic               s2_vld_reg;
    logic [1:0]         s2_leg_reg;
    logic signed [16:0] s2_px_reg, s2_py_reg, s2_pz_reg, s2_h_reg;
    logic signed [33:0] s2_px2_reg, s2_py2_reg, s2_pz2_reg, s2_h2_reg;
    logic [31:0]        s2_u2_reg, s2_w2_reg, s2_uw_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_leg_reg <= s1_leg_reg;
            s2_px_reg  <= s1_px_reg;
            s2_py_reg  <= s1_py_reg;
            s2_pz_reg  <= s1_pz_reg;
            s2_h_reg   <= s1_h_reg;
            s2_px2_reg <= s1_px_reg * s1_px_reg;
            s2_py2_reg <= s1_py_reg * s1_py_reg;
            s2_pz2_reg <= s1_pz_reg * s1_pz_reg;
            s2_h2_reg  <= s1_h_reg * s1_h_reg;
            s2_u2_reg  <= s1_u_reg * s1_u_reg;
            s2_w2_reg  <= s1_w_reg * s1_w_reg;
            s2_uw_reg  <= s1_u_reg * s1_w_reg;
        end
    end

    // ---------------- stage 3: law of cosines terms ----------------
    logic               s3_vld_reg;
    logic [1:0]         s3_leg_reg;
    logic signed [16:0] s3_px_reg, s3_py_reg, s3_pz_reg, s3_h_reg;
    logic signed [35:0] s3_num_reg;
    logic [32:0]        s3_den_reg, s3_u2w2_reg;
    logic [31:0]        s3_px2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_leg_reg  <= s2_leg_reg;
            s3_px_reg   <= s2_px_reg;
            s3_py_reg   <= s2_py_reg;
            s3_pz_reg   <= s2_pz_reg;
            s3_h_reg    <= s2_h_reg;
            s3_num_reg  <= (36'(s2_px2_reg) + 36'(s2_py2_reg) + 36'(s2_pz2_reg))
                         - (36'(s2_h2_reg) + $signed({4'b0, s2_u2_reg})
                            + $signed({4'b0, s2_w2_reg}));
            s3_den_reg  <= {s2_uw_reg, 1'b0};
            s3_u2w2_reg <= {1'b0, s2_u2_reg} + {1'b0, s2_w2_reg};
            s3_px2_reg  <= s2_px2_reg[31:0];
        end
    end

    // ---------------- stage 4: clamp to [-den, den] ----------------
    logic signed [35:0] dens, n4;
    logic               cl4;

    always_comb begin
        dens = $signed({3'b0, s3_den_reg});
        n4   = s3_num_reg;
        cl4  = 1'b0;
        if (s3_num_reg > dens) begin
            n4  = dens;
            cl4 = 1'b1;
        end else if (s3_num_reg < -dens) begin
            n4  = -dens;
            cl4 = 1'b1;
        end
    end

    logic               s4_vld_reg;
    logic [1:0]         s4_leg_reg;
    logic signed [16:0] s4_px_reg, s4_py_reg, s4_pz_reg, s4_h_reg;
    logic               s4_cl_reg, s4_nneg_reg, s4_dz_reg;
    logic [33:0]        s4_mag_reg;
    logic [32:0]        s4_den_reg;
    logic [5:0]         s4_dpos_reg;
    logic signed [35:0] s4_l2_reg;
    logic [31:0]        s4_px2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_leg_reg  <= s3_leg_reg;
            s4_px_reg   <= s3_px_reg;
            s4_py_reg   <= s3_py_reg;
            s4_pz_reg   <= s3_pz_reg;
            s4_h_reg    <= s3_h_reg;
            s4_cl_reg   <= cl4;
            s4_nneg_reg <= n4 < 0;
            s4_mag_reg  <= (n4 < 0) ? 34'(-n4) : 34'(n4);
            s4_dz_reg   <= s3_den_reg == '0;
            s4_den_reg  <= s3_den_reg;
            s4_dpos_reg <= msb_pos(ARG_W'(s3_den_reg));
            s4_l2_reg   <= $signed({3'b0, s3_u2w2_reg}) + n4;
            s4_px2_reg  <= s3_px2_reg;
        end
    end

    // ---------------- stage 5: reach check, acos argument normalization ----------------
    logic signed [35:0] r5;
    logic [33:0]        d5, m5;
    ctx_t               ctx5;

    always_comb begin
        r5 = s4_l2_reg - $signed({4'b0, s4_px2_reg});
        // den lands in [2^30, 2^31), magnitude moves along
        if (s4_dpos_reg > 6'd30) begin
            d5 = {1'b0, s4_den_reg} >> (s4_dpos_reg - 6'd30);
            m5 = s4_mag_reg >> (s4_dpos_reg - 6'd30);
        end else begin
            d5 = {1'b0, s4_den_reg} << (6'd30 - s4_dpos_reg);
            m5 = s4_mag_reg << (6'd30 - s4_dpos_reg);
        end
        ctx5.px           = s4_px_reg;
        ctx5.py           = s4_py_reg;
        ctx5.pz           = s4_pz_reg;
        ctx5.h            = s4_h_reg;
        ctx5.n_neg        = s4_nneg_reg;
        ctx5.mag          = m5[30:0];
        ctx5.den_zero     = s4_dz_reg;
        ctx5.tag.leg      = s4_leg_reg;
        ctx5.tag.clamped  = s4_cl_reg || (r5 < 0);
        ctx5.tag.zero_len = s4_l2_reg == 0;
    end

    logic        s5_vld_reg;
    ctx_t        s5_ctx_reg;
    logic [30:0] s5_d_reg;
    logic [63:0] s5_radm_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_ctx_reg  <= ctx5;
            s5_d_reg    <= d5[30:0];
            s5_radm_reg <= (r5 < 0) ? '0 : {6'b0, r5[33:0], 24'b0};
        end
    end

    // ---------------- stage 6: squares of the normalized pair ----------------
    logic        s6_vld_reg;
    ctx_t        s6_ctx_reg;
    logic [61:0] s6_dd_reg, s6_mm_reg;
    logic [63:0] s6_radm_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_ctx_reg  <= s5_ctx_reg;
            s6_dd_reg   <= s5_d_reg * s5_d_reg;
            s6_mm_reg   <= s5_ctx_reg.mag * s5_ctx_reg.mag;
            s6_radm_reg <= s5_radm_reg;
        end
    end

    // ---------------- stage 7 and square-root rows ----------------
    // sq_ctx_reg[0] is stage 7, entry k+1 rides along with digit cell k
    logic        sq_vld_reg [0:SQ_STEPS];
    ctx_t        sq_ctx_reg [0:SQ_STEPS];
    logic [63:0] s7_rada_reg, s7_radm_reg;
    sq_t         sqa_link   [0:SQ_STEPS];
    sq_t         sqm_link   [0:SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_rada_reg   <= {2'b0, s6_dd_reg - s6_mm_reg};
            s7_radm_reg   <= s6_radm_reg;
            sq_ctx_reg[0] <= s6_ctx_reg;
            for (int k = 1; k <= SQ_STEPS; k++) begin
                sq_ctx_reg[k] <= sq_ctx_reg[k-1];
            end
        end
    end

    assign sqa_link[0] = '{v: s7_rada_reg, r: '0};
    assign sqm_link[0] = '{v: s7_radm_reg, r: '0};

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        lik_sqrt_cell u_sqa (
            .aclk  (aclk),
            .en    (adv),
            .step  (5'(k)),
            .d_in  (sqa_link[k]),
            .d_out (sqa_link[k+1])
        );
        lik_sqrt_cell u_sqm (
            .aclk  (aclk),
            .en    (adv),
            .step  (5'(k)),
            .d_in  (sqm_link[k]),
            .d_out (sqm_link[k+1])
        );
    end

    // ---------------- p1: products for the abduction terms ----------------
    ctx_t               sq_out;
    logic signed [29:0] mb30;

    assign sq_out = sq_ctx_reg[SQ_STEPS];
    assign mb30   = $signed({1'b0, sqm_link[SQ_STEPS].r[28:0]});

    logic                    p1_vld_reg;
    tag_t                    p1_tag_reg;
    logic signed [ARG_W-1:0] p1_ya_reg, p1_xa_reg, p1_yb_reg, p1_xb_reg;
    logic signed [ARG_W-1:0] p1_mpz_reg, p1_mpy_reg;
    logic signed [33:0]      p1_hpy_reg, p1_hpz_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_tag_reg <= sq_out.tag;
            // acos argument pair, forced to the origin when den is zero
            if (sq_out.den_zero) begin
                p1_ya_reg <= '0;
                p1_xa_reg <= '0;
            end else begin
                p1_ya_reg <= $signed({17'b0, sqa_link[SQ_STEPS].r[30:0]});
                p1_xa_reg <= sq_out.n_neg ? -$signed({17'b0, sq_out.mag})
                                          : $signed({17'b0, sq_out.mag});
            end
            // asin argument pair
            p1_yb_reg  <= -(ARG_W'(sq_out.px) <<< 12);
            p1_xb_reg  <= ARG_W'(mb30);
            p1_hpy_reg <= sq_out.h * sq_out.py;
            p1_hpz_reg <= sq_out.h * sq_out.pz;
            p1_mpz_reg <= mb30 * sq_out.pz;
            p1_mpy_reg <= mb30 * sq_out.py;
        end
    end

    // ---------------- p2: abduction vector ----------------
    logic signed [ARG_W-1:0] p2_ya_reg, p2_xa_reg, p2_yb_reg, p2_xb_reg;
    logic signed [ARG_W-1:0] p2_c1_reg, p2_s1_reg;

    // tag line: entry 0 is p2, the last one sits beside the final cordic cell
    localparam int TG_LEN = CD_STEPS + 2;
    logic tg_vld_reg [0:TG_LEN];
    tag_t tg_reg     [0:TG_LEN];

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_ya_reg <= p1_ya_reg;
            p2_xa_reg <= p1_xa_reg;
            p2_yb_reg <= p1_yb_reg;
            p2_xb_reg <= p1_xb_reg;
            p2_c1_reg <= (ARG_W'(p1_hpy_reg) <<< 12) - p1_mpz_reg;
            p2_s1_reg <= p1_mpy_reg + (ARG_W'(p1_hpz_reg) <<< 12);
            tg_reg[0] <= p1_tag_reg;
            for (int k = 1; k <= TG_LEN; k++) begin
                tg_reg[k] <= tg_reg[k-1];
            end
        end
    end

    // ---------------- three atan2 rows ----------------
    cd_t cda_link [0:CD_STEPS];
    cd_t cdb_link [0:CD_STEPS];
    cd_t cdc_link [0:CD_STEPS];

    lik_cordic_prep u_prep_acos (
        .aclk(aclk), .en(adv), .y_in(p2_ya_reg), .x_in(p2_xa_reg), .d_out(cda_link[0])
    );
    lik_cordic_prep u_prep_asin (
        .aclk(aclk), .en(adv), .y_in(p2_yb_reg), .x_in(p2_xb_reg), .d_out(cdb_link[0])
    );
    lik_cordic_prep u_prep_abd (
        .aclk(aclk), .en(adv), .y_in(p2_s1_reg), .x_in(p2_c1_reg), .d_out(cdc_link[0])
    );

    for (genvar k = 0; k < CD_STEPS; k++) begin : g_cordic
        lik_cordic_cell u_cda (
            .aclk(aclk), .en(adv), .step(5'(k)), .d_in(cda_link[k]), .d_out(cda_link[k+1])
        );
        lik_cordic_cell u_cdb (
            .aclk(aclk), .en(adv), .step(5'(k)), .d_in(cdb_link[k]), .d_out(cdb_link[k+1])
        );
        lik_cordic_cell u_cdc (
            .aclk(aclk), .en(adv), .step(5'(k)), .d_in(cdc_link[k]), .d_out(cdc_link[k+1])
        );
    end

    // ---------------- output rounding and register ----------------
    function automatic logic [15:0] sat16(input logic signed [35:0] v);
        logic [15:0] o;
        if (v > 36'sd32767) begin
            o = 16'h7fff;
        end else if (v < -36'sd32768) begin
            o = 16'h8000;
        end else begin
            o = v[15:0];
        end
        return o;
    endfunction

    logic signed [35:0] acos_z, asin_z, abd_z, knee_f, hip2_f;
    logic [15:0]        ab_o, hip_o, knee_o;
    tag_t               tag_o;

    always_comb begin
        acos_z = cda_link[CD_STEPS].zero ? '0 : 36'(cda_link[CD_STEPS].z);
        asin_z = cdb_link[CD_STEPS].zero ? '0 : 36'(cdb_link[CD_STEPS].z);
        abd_z  = cdc_link[CD_STEPS].zero ? '0 : 36'(cdc_link[CD_STEPS].z);
        knee_f = -acos_z;
        // hip = asin - knee/2, kept at 2^-31 rad
        hip2_f = (asin_z <<< 1) + acos_z;
        // round half up to 2^-13 rad
        ab_o   = sat16((abd_z + 36'sd65536) >>> 17);
        knee_o = sat16((knee_f + 36'sd65536) >>> 17);
        hip_o  = sat16((hip2_f + 36'sd131072) >>> 18);
        tag_o  = tg_reg[TG_LEN];
    end

    logic        m_tvalid_reg;
    logic [15:0] m_ab_reg, m_hip_reg, m_knee_reg;
    logic [3:0]  m_fji_reg;
    logic        m_cl_reg, m_zl_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_ab_reg   <= ab_o;
            m_hip_reg  <= hip_o;
            m_knee_reg <= knee_o;
            m_fji_reg  <= 4'(JOINTS_PER_LEG * int'(tag_o.leg));
            m_cl_reg   <= tag_o.clamped;
            m_zl_reg   <= tag_o.zero_len;
        end
    end

    // ---------------- valid line ----------------
    // tg_vld_reg[0] sits beside tg_reg[0], the p2 stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            s4_vld_reg   <= 1'b0;
            s5_vld_reg   <= 1'b0;
            s6_vld_reg   <= 1'b0;
            p1_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++) begin
                sq_vld_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= TG_LEN; k++) begin
                tg_vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            s1_vld_reg    <= s_tvalid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            s5_vld_reg    <= s4_vld_reg;
            s6_vld_reg    <= s5_vld_reg;
            sq_vld_reg[0] <= s6_vld_reg;
            for (int k = 1; k <= SQ_STEPS; k++) begin
                sq_vld_reg[k] <= sq_vld_reg[k-1];
            end
            p1_vld_reg    <= sq_vld_reg[SQ_STEPS];
            tg_vld_reg[0] <= p1_vld_reg;
            for (int k = 1; k <= TG_LEN; k++) begin
                tg_vld_reg[k] <= tg_vld_reg[k-1];
            end
            m_tvalid_reg  <= tg_vld_reg[TG_LEN];
        end
    end

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b0, m_zl_reg, m_cl_reg, m_fji_reg, m_knee_reg, m_hip_reg, m_ab_reg};

`ifndef SYNTH
    // knee solution always bends one way
    a_knee_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_knee_reg[15] || m_knee_reg == 16'd0))
        else $error("knee angle positive");

    a_joint_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_fji_reg == 4'd0 || m_fji_reg == 4'd3
                          || m_fji_reg == 4'd6 || m_fji_reg == 4'd9))
        else $error("first joint index off the leg grid");

    // a held result freezes the cordic tail
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(tg_vld_reg[TG_LEN]))
        else $error("pipe moved while output stalled");
`endif

endmodule

[test/leg_ik_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leg_ik_checker
// watches the config port and both streams, predicts each solution and
// compares it field by field with the result beats in order
// ----------------------------------------------------------------------------
module leg_ik_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          fail_count,
    output int          outstanding
);
    import lik_pkg::*;

    // highest field first, so abduction lands in the low bits
    typedef struct packed {
        logic               zero_len;
        logic               clamped;
        logic [3:0]         joint;
        logic signed [15:0] knee;
        logic signed [15:0] hip;
        logic signed [15:0] abduction;
    } leg_solution_t;

    localparam longint HALF_TURN = 64'sd3373259426;
    localparam longint ARCTAN_STEP [31] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
        524288, 262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

    logic [15:0] link_hip, link_upper, link_lower;
    logic [47:0] hip_mount [4];
    leg_solution_t solutions_due [$];

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // vectoring cordic, angle in 2^-30 rad
    function automatic longint vector_angle(input longint y, input longint x);
        longint z, mag, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        mag = x;
        if ((y < 0 ? -y : y) > mag) mag = (y < 0 ? -y : y);
        while (mag >= (64'sd1 << 41)) begin
            x = x >>> 1;
            y = y >>> 1;
            mag = mag >>> 1;
        end
        while (mag < (64'sd1 << 40)) begin
            x = x * 2;
            y = y * 2;
            mag = mag * 2;
        end
        for (int i = 0; i < 31; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_STEP[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_STEP[i];
            end
        end
        return z;
    endfunction

    function automatic logic [15:0] to_angle(input longint v, input int s);
        longint r;
        r = (v + (64'sd1 <<< (s - 1))) >>> s;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic leg_solution_t solve_leg(input logic [55:0] beat);
        leg_solution_t sol;
        logic [1:0] leg;
        logic [47:0] off;
        longint px, py, pz, h, u, w, den, num, n, acos_a, knee, asin_a;
        longint l2, r, m, c1, s1, ab;
        longint unsigned d, mag;
        logic clamp;
        leg = beat[1:0];
        off = hip_mount[leg];
        px = longint'($signed(beat[17:2])) - longint'($signed(off[15:0]));
        py = longint'($signed(beat[33:18])) - longint'($signed(off[31:16]));
        pz = longint'($signed(beat[49:34])) - longint'($signed(off[47:32]));
        h = leg[0] ? longint'(link_hip) : -longint'(link_hip);
        u = link_upper;
        w = link_lower;
        den = 2 * u * w;
        num = px * px + py * py + pz * pz - (h * h + u * u + w * w);
        n = num;
        clamp = 1'b0;
        acos_a = 0;
        if (n > den) begin
            n = den;
            clamp = 1'b1;
        end else if (n < -den) begin
            n = -den;
            clamp = 1'b1;
        end
        if (den != 0) begin
            d = den;
            mag = (n < 0) ? -n : n;
            while (d >= (64'd1 << 31)) begin
                d = d >> 1;
                mag = mag >> 1;
            end
            while (d < (64'd1 << 30)) begin
                d = d << 1;
                mag = mag << 1;
            end
            acos_a = vector_angle(longint'(floor_sqrt(d * d - mag * mag)),
                                  (n < 0) ? -longint'(mag) : longint'(mag));
        end
        knee = -acos_a;
        l2 = u * u + w * w + n;
        r = l2 - px * px;
        if (r < 0) begin
            r = 0;
            clamp = 1'b1;
        end
        m = floor_sqrt(longint'(r) << 24);
        asin_a = vector_angle(-px * 4096, m);
        c1 = h * py * 4096 - m * pz;
        s1 = m * py + h * pz * 4096;
        ab = vector_angle(s1, c1);
        sol.abduction = to_angle(ab, 17);
        sol.hip       = to_angle(2 * asin_a - knee, 18);
        sol.knee      = to_angle(knee, 17);
        sol.joint     = 4'(JOINTS_PER_LEG * leg);
        sol.clamped   = clamp;
        sol.zero_len  = (l2 == 0);
        return sol;
    endfunction

    always @(posedge aclk) begin
        leg_solution_t due, got;
        if (!aresetn) begin
            link_hip <= 16'd340;
            link_upper <= 16'd819;
            link_lower <= 16'd819;
            for (int i = 0; i < 4; i++) hip_mount[i] <= '0;
            solutions_due.delete();
            fail_count <= 0;
            outstanding <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_HIP_LENGTH:   link_hip <= cfg_wdata[15:0];
                    REG_UPPER_LENGTH: link_upper <= cfg_wdata[15:0];
                    REG_LOWER_LENGTH: link_lower <= cfg_wdata[15:0];
                    REG_HIP_OFFSET0:  hip_mount[0] <= cfg_wdata;
                    REG_HIP_OFFSET1:  hip_mount[1] <= cfg_wdata;
                    REG_HIP_OFFSET2:  hip_mount[2] <= cfg_wdata;
                    REG_HIP_OFFSET3:  hip_mount[3] <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) solutions_due.push_back(solve_leg(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[53:0];
                if (solutions_due.size() == 0) begin
                    $error("result beat with nothing expected: %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    due = solutions_due.pop_front();
                    if (got != due) begin
                        fail_count <= fail_count + 1;
                        if (got.abduction != due.abduction)
                            $error("abduction_angle exp %0d got %0d", due.abduction,
                                   got.abduction);
                        if (got.hip != due.hip)
                            $error("hip_angle exp %0d got %0d", due.hip, got.hip);
                        if (got.knee != due.knee)
                            $error("knee_angle exp %0d got %0d", due.knee, got.knee);
                        if (got.joint != due.joint)
                            $error("first_joint_index exp %0d got %0d", due.joint,
                                   got.joint);
                        if (got.clamped != due.clamped)
                            $error("reach_clamped exp %0d got %0d", due.clamped,
                                   got.clamped);
                        if (got.zero_len != due.zero_len)
                            $error("zero_length exp %0d got %0d", due.zero_len,
                                   got.zero_len);
                    end
                end
            end
            outstanding <= solutions_due.size();
        end
    end

endmodule

[test/tb_leg_inverse_kinematics.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_leg_inverse_kinematics
// stimulus and verdict for the leg inverse kinematics solver
// ----------------------------------------------------------------------------
// Runs the block through several link and hip offset settings. Each setting
// gets a few directed foot positions and then random ones, mostly around the
// hip within the leg's span, under changing idle and stall patterns. The
// checker predicts every solution and compares the result beats.
// ----------------------------------------------------------------------------
module tb_leg_inverse_kinematics;
    import lik_pkg::*;

    localparam int NUM_SETTINGS  = 8;
    localparam int BEATS_PER_SET = 176;
    localparam int DRAIN_CYCLES  = 100;   // pipe is 75 deep
    localparam int CYCLE_LIMIT   = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;   // leg_id, foot_x, foot_y, foot_z from bit 0 up
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // abduction, hip, knee, joint index, clamp, zero length

    int fail_count, outstanding;
    int cycle_count = 0;
    int idle_mode = 0;            // 0 none, 1 sender idles, 2 receiver stalls, 3 both
    int reach;                    // rough leg span of the current setting
    logic [47:0] offsets [4];

    leg_inverse_kinematics dut (.*);

    leg_ik_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        case (idle_mode)
            2:       m_tready <= ($urandom_range(0, 99) >= 57);
            3:       m_tready <= ($urandom_range(0, 99) >= 17);
            default: m_tready <= 1'b1;
        endcase
    end

    task automatic write_settings(input logic [15:0] h, input logic [15:0] u,
                                  input logic [15:0] w);
        logic [47:0] vals [7];
        vals = '{48'(h), 48'(u), 48'(w), offsets[0], offsets[1], offsets[2], offsets[3]};
        for (int i = 0; i < 7; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        reach = int'(h) + int'(u) + int'(w) + 1;
    endtask

    // one input beat, with random gaps before it in the idling phases
    task automatic send_foot(input logic [1:0] leg, input logic [15:0] fx,
                             input logic [15:0] fy, input logic [15:0] fz);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 57 : (idle_mode == 3) ? 17 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, fz, fy, fx, leg};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [15:0] near(input logic [15:0] center, input int span);
        return center + 16'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic random_foot();
        logic [1:0] leg;
        int span;
        leg = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 70) begin
            // mostly within the leg's span around the hip
            span = (reach > 30000) ? 30000 : reach;
            send_foot(leg, near(offsets[leg][15:0], span), near(offsets[leg][31:16], span),
                      near(offsets[leg][47:32], span));
        end else begin
            send_foot(leg, 16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (outstanding != 0 || checker_i.solutions_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < 4; i++) offsets[i] = '0;
        reach = 340 + 819 + 819;

        for (int set = 0; set < NUM_SETTINGS; set++) begin
            // first setting runs on reset values
            case (set)
                0: ;
                1: begin
                    for (int i = 0; i < 4; i++)
                        offsets[i] = {near(16'd0, 500), near(16'd0, 500), near(16'd0, 500)};
                    write_settings(16'd340, 16'd819, 16'd819);
                end
                2: begin
                    // no hip link: a foot at the hip gives the undefined abduction
                    for (int i = 0; i < 4; i++) offsets[i] = '0;
                    write_settings(16'd0, 16'd1000, 16'd800);
                end
                3: begin
                    // no links at all: zero link product and zero length
                    for (int i = 0; i < 4; i++) offsets[i] = {near(16'd0, 50), near(16'd0, 50),
                                                            near(16'd0, 50)};
                    write_settings(16'd0, 16'd0, 16'd0);
                end
                4: begin
                    offsets[0] = {16'h7fff, 16'h7fff, 16'h7fff};
                    offsets[1] = {16'h8000, 16'h8000, 16'h8000};
                    offsets[2] = {16'h7fff, 16'h8000, 16'h7fff};
                    offsets[3] = {16'h8000, 16'h7fff, 16'h8000};
                    write_settings(16'hffff, 16'hffff, 16'hffff);
                end
                5: begin
                    for (int i = 0; i < 4; i++) offsets[i] = 48'({$urandom, $urandom});
                    write_settings(16'($urandom), 16'($urandom), 16'($urandom));
                end
                6: begin
                    // one link missing
                    for (int i = 0; i < 4; i++) offsets[i] = {near(16'd0, 300),
                                                            near(16'd0, 300),
                                                            near(16'd0, 300)};
                    write_settings(16'd200, 16'd1200, 16'd0);
                end
                default: begin
                    for (int i = 0; i < 4; i++) offsets[i] = {near(16'd0, 2000),
                                                            near(16'd0, 2000),
                                                            near(16'd0, 2000)};
                    write_settings(16'd120, 16'd2000, 16'd1500);
                end
            endcase
            idle_mode = set % 4;

            // directed corners for every leg
            for (int leg = 0; leg < 4; leg++) begin
                send_foot(2'(leg), offsets[leg][15:0], offsets[leg][31:16],
                          offsets[leg][47:32]);
                send_foot(2'(leg), 16'h7fff, 16'h7fff, 16'h7fff);
                send_foot(2'(leg), 16'h8000, 16'h8000, 16'h8000);
                // straight below the hip at half span
                send_foot(2'(leg), offsets[leg][15:0], offsets[leg][31:16],
                          offsets[leg][47:32] - 16'(reach / 2));
            end
            send_foot(2'd1, offsets[1][15:0] + 16'(reach), offsets[1][31:16],
                      offsets[1][47:32]);
            send_foot(2'd2, offsets[2][15:0] - 16'(reach), offsets[2][31:16],
                      offsets[2][47:32]);

            for (int k = 0; k < BEATS_PER_SET; k++) random_foot();
            // hold the sender until every solution is back
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
